>>> sv/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  // Field widths
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned TRASH_W = 3;
  localparam int unsigned BYTE_W  = 8;

  // Table geometry and default code length limit
  localparam int unsigned TABLE_DEPTH      = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  // Bit position of the first free bit in an empty byte
  localparam logic [POS_W-1:0] TOP_BIT = 3'd7;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  addr;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

  // Table read request
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
  } tbl_req_t;

  // Table read data, registered: valid in the cycle after the request
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } tbl_rd_t;

endpackage

>>> sv/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hcbp_table.sv
// Code table: word/length RAM plus per-entry valid bits that clear at reset.
module hcbp_table #(
  parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcbp_pkg::tbl_wr_t  wr_i,
  input  hcbp_pkg::tbl_req_t req_i,
  output hcbp_pkg::tbl_rd_t  rd_o
);

  // Stored length is capped at the smaller of the limit and the word width
  localparam int unsigned CapLen = (MAX_CODE_LEN < hcbp_pkg::WORD_W) ?
                                   MAX_CODE_LEN : hcbp_pkg::WORD_W;
  localparam int unsigned LenW   = $clog2(CapLen + 1);
  localparam int unsigned RamW   = hcbp_pkg::WORD_W + LenW;

  logic [LenW-1:0]                 len_cap;
  logic [RamW-1:0]                 rdata;
  logic [hcbp_pkg::TABLE_DEPTH-1:0] vld_q;
  logic                            rd_vld_q;

  // Saturate the loaded length
  assign len_cap = (wr_i.len > hcbp_pkg::LEN_W'(CapLen)) ? LenW'(CapLen) : LenW'(wr_i.len);

  hcbp_ram #(
    .Width (RamW),
    .Depth (hcbp_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i ({wr_i.word, len_cap}),
    .re_i    (req_i.en),
    .raddr_i (req_i.addr),
    .rdata_o (rdata)
  );

  // Valid bits: an entry never loaded reads as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (req_i.en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rd_o.word = rdata[RamW-1:LenW];
  assign rd_o.len  = rd_vld_q ? hcbp_pkg::LEN_W'(rdata[LenW-1:0]) : '0;

endmodule

>>> sv/hcbp_packer.sv
// Sequencer and shared shift/merge unit that packs codes into output bytes.
module hcbp_packer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [hcbp_pkg::SYM_W-1:0]        symbol_i,
  input  logic [hcbp_pkg::WORD_W-1:0]       code_bits_i,
  input  logic [hcbp_pkg::LEN_W-1:0]        code_length_i,
  // table port
  output hcbp_pkg::tbl_wr_t                 tbl_wr_o,
  output hcbp_pkg::tbl_req_t                tbl_req_o,
  input  hcbp_pkg::tbl_rd_t                 tbl_rd_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                              byte_valid_o,
  output logic                              last_o,
  output logic [hcbp_pkg::TRASH_W-1:0]      trash_bits_o,
  output logic                              is_flush_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_PACK   = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [hcbp_pkg::WORD_W-1:0]  word_q, word_d;
  logic [hcbp_pkg::LEN_W-1:0]   rem_q, rem_d;
  logic [hcbp_pkg::BYTE_W-1:0]  pend_q, pend_d;
  logic [hcbp_pkg::POS_W-1:0]   pos_q, pos_d;

  logic                         ov_q, ov_d;
  logic [hcbp_pkg::BYTE_W-1:0]  ob_q, ob_d;
  logic                         obv_q, obv_d;
  logic                         ol_q, ol_d;
  logic [hcbp_pkg::TRASH_W-1:0] ot_q, ot_d;
  logic                         of_q, of_d;

  logic                         accept;
  logic                         can_push;

  // shift/merge unit signals
  logic [3:0]                   free;
  logic [3:0]                   take;
  logic [hcbp_pkg::LEN_W-1:0]   shamt;
  logic [hcbp_pkg::WORD_W-1:0]  shifted;
  logic [hcbp_pkg::BYTE_W-1:0]  mask;
  logic [hcbp_pkg::BYTE_W-1:0]  chunk;
  logic [hcbp_pkg::BYTE_W-1:0]  merged;
  logic [hcbp_pkg::LEN_W-1:0]   rem_after;
  logic                         byte_done;
  logic                         step_go;

  // Input handshake and table requests
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign tbl_wr_o.en   = accept && (kind_i == hcbp_pkg::KIND_LOAD);
  assign tbl_wr_o.addr = symbol_i;
  assign tbl_wr_o.word = code_bits_i;
  assign tbl_wr_o.len  = code_length_i;

  assign tbl_req_o.en   = accept && (kind_i == hcbp_pkg::KIND_ENCODE);
  assign tbl_req_o.addr = symbol_i;

  // Output register frees up when empty or being taken
  assign can_push = !ov_q || !out_stall_i;

  // Shared unit: move min(remaining, free) code bits into the pending byte
  assign free      = {1'b0, pos_q} + 4'd1;
  assign take      = (rem_q < hcbp_pkg::LEN_W'(free)) ? rem_q[3:0] : free;
  assign shamt     = rem_q - hcbp_pkg::LEN_W'(take);
  assign shifted   = word_q >> shamt;
  assign mask      = hcbp_pkg::BYTE_W'((9'd1 << take) - 9'd1);
  assign chunk     = hcbp_pkg::BYTE_W'((shifted[hcbp_pkg::BYTE_W-1:0] & mask) << (free - take));
  assign merged    = pend_q | chunk;
  assign rem_after = rem_q - hcbp_pkg::LEN_W'(take);
  assign byte_done = (take == free);
  assign step_go   = !byte_done || can_push;

  // Sequencer
  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    rem_d   = rem_q;
    pend_d  = pend_q;
    pos_d   = pos_q;
    ov_d    = ov_q && out_stall_i;
    ob_d    = ob_q;
    obv_d   = obv_q;
    ol_d    = ol_q;
    ot_d    = ot_q;
    of_d    = of_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            hcbp_pkg::KIND_ENCODE: state_d = ST_LOOKUP;
            hcbp_pkg::KIND_FLUSH:  state_d = ST_FLUSH;
            default:               state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        word_d  = tbl_rd_i.word;
        rem_d   = tbl_rd_i.len;
        state_d = (tbl_rd_i.len == '0) ? ST_IDLE : ST_PACK;
      end
      ST_PACK: begin
        if (step_go) begin
          rem_d = rem_after;
          if (byte_done) begin
            // completed byte goes out; it is last if no full byte remains
            ov_d   = 1'b1;
            ob_d   = merged;
            obv_d  = 1'b1;
            ol_d   = (rem_after < hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W));
            ot_d   = '0;
            of_d   = 1'b0;
            pend_d = '0;
            pos_d  = hcbp_pkg::TOP_BIT;
          end else begin
            pend_d = merged;
            pos_d  = pos_q - hcbp_pkg::POS_W'(take);
          end
          if (rem_after == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          ov_d = 1'b1;
          ol_d = 1'b1;
          of_d = 1'b1;
          if (pos_q != hcbp_pkg::TOP_BIT) begin
            ob_d  = pend_q;
            obv_d = 1'b1;
            ot_d  = pos_q + 3'd1;
          end else begin
            ob_d  = '0;
            obv_d = 1'b0;
            ot_d  = '0;
          end
          pend_d  = '0;
          pos_d   = hcbp_pkg::TOP_BIT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      pend_q  <= '0;
      pos_q   <= hcbp_pkg::TOP_BIT;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    ob_q   <= ob_d;
    obv_q  <= obv_d;
    ol_q   <= ol_d;
    ot_q   <= ot_d;
    of_q   <= of_d;
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign byte_valid_o = obv_q;
  assign last_o       = ol_q;
  assign trash_bits_o = ot_q;
  assign is_flush_o   = of_q;

endmodule

>>> sv/huffman_code_bit_packer.sv
// Huffman code bit packer: 256-entry code table and MSB-first byte packer.
//
// Input channel (in_valid_i / in_stall_o) takes one word of kind load, encode
// or flush. Load writes a code word and length into the table in the accept
// cycle and does not stall the input. Encode reads the table in ST_LOOKUP,
// then the shared shift/merge unit moves up to one byte's worth of code bits
// per cycle into the pending byte, unless a completed byte waits on a stalled
// output: L code bits with P bits pending take ceil((L + P) / 8) steps, at
// most five. An encode stalls the input through ST_LOOKUP and ST_PACK, or
// ST_LOOKUP alone for a symbol with no code; a flush, through ST_FLUSH. Result
// words are registered from ST_PACK (after ST_LOOKUP) and from ST_FLUSH.
// Output channel (out_valid_o / out_stall_i) carries one result word per
// handshake from a single output register; each completed byte is one word,
// a flush gives exactly one word with is_flush_o and trash_bits_o.
// If the receiver stalls, packing waits at the next completed byte, and the
// input stays stalled until the current word's results are all registered.
// Reset clears all table lengths (per-entry valid bits), the pending byte and
// the bit position; code words are undefined until loaded.
module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol_i,
  input  logic [hcbp_pkg::WORD_W-1:0]  code_bits_i,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hcbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                         byte_valid_o,
  output logic                         last_o,
  output logic [hcbp_pkg::TRASH_W-1:0] trash_bits_o,
  output logic                         is_flush_o
);

  hcbp_pkg::tbl_wr_t  tbl_wr;
  hcbp_pkg::tbl_req_t tbl_req;
  hcbp_pkg::tbl_rd_t  tbl_rd;

  // Code table
  hcbp_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .req_i  (tbl_req),
    .rd_o   (tbl_rd)
  );

  // Sequencer and packing unit
  hcbp_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .tbl_wr_o      (tbl_wr),
    .tbl_req_o     (tbl_req),
    .tbl_rd_i      (tbl_rd),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .trash_bits_o  (trash_bits_o),
    .is_flush_o    (is_flush_o)
  );

`ifndef SYNTHESIS
  // An accepted encode keeps the input stalled for the lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == hcbp_pkg::KIND_ENCODE) |=> in_stall_o)
    else $error("encode accepted without stalling for lookup");

  // A flush word is always the last of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_flush_o |-> last_o)
    else $error("flush word without last");

  // Encode words always carry a byte and no trash count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_flush_o |-> byte_valid_o && (trash_bits_o == '0))
    else $error("bad encode result word");

  // A nonzero trash count only comes with a partial flush byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (trash_bits_o != '0) |-> is_flush_o && byte_valid_o)
    else $error("trash count outside a partial flush");
`endif

endmodule
